// File: hw/rtl/ip_prefix_allowlist_match_defines.svh
// ----------------------------------------------------------------------------
// ip_prefix_allowlist_match assertion macros
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef IP_PREFIX_ALLOWLIST_MATCH_DEFINES_SVH
`define IP_PREFIX_ALLOWLIST_MATCH_DEFINES_SVH
`ifndef SYNTH
`define IPAL_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ipal assertion failed");
`define IPAL_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("ipal forbidden condition seen");
`else
`define IPAL_ASSERT(label, clk, rst, prop)
`define IPAL_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// File: hw/rtl/ipal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipal_pkg
// shared types, codes and helpers of the prefix allowlist
// ----------------------------------------------------------------------------
package ipal_pkg;

   localparam int IPAL_MAX_ENTRIES = 256;
   localparam int IPAL_QUEUE_DEPTH = 2;

   localparam logic [1:0] CMD_CLEAR  = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_PRESENT = 2'd1;
   localparam logic [1:0] STAT_INVALID = 2'd2;
   localparam logic [1:0] STAT_FULL    = 2'd3;

   localparam logic [7:0] V4_MAX_PLEN = 8'd32;
   localparam logic [7:0] V6_MAX_PLEN = 8'd128;
   localparam logic [7:0] V6_MIN_PLEN = 8'd10;
   localparam logic [9:0] V6_LINK_LOCAL = 10'h3fa;
   localparam logic [7:0] V6_MULTICAST  = 8'hff;

   typedef enum logic [2:0] {
      OP_CLEAR   = 3'd0,
      OP_ADD     = 3'd1,
      OP_ADD_BAD = 3'd2,
      OP_LOOKUP  = 3'd3,
      OP_NONE    = 3'd4
   } ipal_op_type;

   typedef struct packed {
      ipal_op_type op;
      logic        v6;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [7:0]  plen;
   } ipal_item_type;

   typedef struct packed {
      logic        v6;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [7:0]  plen;
   } ipal_entry_type;

   typedef struct packed {
      logic [8:0] entry_count;
      logic       hit;
      logic [1:0] status;
   } ipal_result_type;

   // top plen bits of a 128 bit key
   function automatic logic [127:0] ipal_prefix_mask(input logic [7:0] plen);
      logic [127:0] m;
      for (int k = 0; k < 128; k++) begin
         m[127-k] = (8'(k) < plen);
      end
      return m;
   endfunction

   // v4 addresses sit at the top of the key so one mask serves both families
   function automatic logic [127:0] ipal_key(input logic v6, input logic [63:0] hi,
                                             input logic [63:0] lo);
      logic [127:0] k;
      if (v6) begin
         k = {hi, lo};
      end else begin
         k = {lo[31:0], 96'd0};
      end
      return k;
   endfunction

endpackage

// File: hw/rtl/ipal_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipal_front
// normalizes the incoming word and classifies the command and add validity
// ----------------------------------------------------------------------------
module ipal_front import ipal_pkg::*; (
   input  logic          req_tvalid,
   input  logic [135:0]  req_tdata,
   input  logic [2:0]    req_tuser,
   output logic          push_valid,
   output ipal_item_type push_item
);

   logic [1:0]  cmd;
   logic        v6;
   logic [63:0] hi;
   logic [63:0] lo;
   logic [7:0]  plen;
   logic        v4_ok;
   logic        v6_ok;
   logic        add_ok;

   always_comb begin
      cmd  = req_tuser[1:0];
      v6   = req_tuser[2];
      hi   = v6 ? req_tdata[63:0] : 64'd0;
      lo   = v6 ? req_tdata[127:64] : {32'd0, req_tdata[95:64]};
      plen = req_tdata[135:128];

      v4_ok = (plen != 8'd0) && (plen <= V4_MAX_PLEN);
      v6_ok = (plen >= V6_MIN_PLEN) && (plen <= V6_MAX_PLEN)
              && !((hi == 64'd0) && (lo == 64'd1))
              && (hi[63:54] != V6_LINK_LOCAL)
              && (hi[63:56] != V6_MULTICAST);
      add_ok = v6 ? v6_ok : v4_ok;

      push_item.v6   = v6;
      push_item.hi   = hi;
      push_item.lo   = lo;
      push_item.plen = plen;
      case (cmd)
         CMD_CLEAR:  push_item.op = OP_CLEAR;
         CMD_ADD:    push_item.op = add_ok ? OP_ADD : OP_ADD_BAD;
         CMD_LOOKUP: push_item.op = OP_LOOKUP;
         default:    push_item.op = OP_NONE;
      endcase
   end

   assign push_valid = req_tvalid;

endmodule

// File: hw/rtl/ipal_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipal_fifo
// short queue of classified words between front and back
// ----------------------------------------------------------------------------
module ipal_fifo import ipal_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push_valid,
   input  ipal_item_type push_item,
   output logic          push_ready,
   output logic          pop_valid,
   output ipal_item_type pop_item,
   input  logic          pop
);

   localparam int PTR_W = (IPAL_QUEUE_DEPTH > 1) ? $clog2(IPAL_QUEUE_DEPTH) : 1;
   localparam int LVL_W = $clog2(IPAL_QUEUE_DEPTH + 1);

   ipal_item_type    slot_ff [IPAL_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (level_ff != LVL_W'(IPAL_QUEUE_DEPTH));
   assign pop_valid  = (level_ff != '0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(IPAL_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(IPAL_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         level_in = level_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         level_in = level_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hw/rtl/ipal_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipal_back
// entry table, sequential scan for duplicates and lookups, result register
// ----------------------------------------------------------------------------
`include "ip_prefix_allowlist_match_defines.svh"
module ipal_back import ipal_pkg::*; #(
   parameter int MAX_ENTRIES = IPAL_MAX_ENTRIES
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  ipal_item_type q_item,
   output logic          q_pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [15:0]   rsp_tdata
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } ipal_state_type;

   ipal_entry_type  mem [MAX_ENTRIES];

   ipal_state_type  state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   ipal_item_type   cur_ff, cur_in;
   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic            cmp_vld_ff, cmp_vld_in;
   logic            cmp_last_ff, cmp_last_in;
   ipal_entry_type  rd_data_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   ipal_result_type rsp_data_ff, rsp_data_in;

   logic            out_free;
   logic            full;
   logic [CNT_W-1:0] count_inc;
   logic [IDX_W-1:0] rd_addr;
   logic            mem_we;
   logic [IDX_W-1:0] mem_waddr;
   ipal_entry_type  mem_wdata;
   logic            dup_hit;
   logic            pfx_hit;
   logic            hit_now;
   logic [127:0]    pfx_mask;

   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign full      = (count_ff >= CNT_W'(MAX_ENTRIES));
   assign count_inc = count_ff + CNT_W'(1);
   assign rd_addr   = rd_cnt_ff[IDX_W-1:0];
   assign mem_waddr = count_ff[IDX_W-1:0];

   // compare of the entry read in the previous cycle
   always_comb begin
      pfx_mask = ipal_prefix_mask(rd_data_ff.plen);
      dup_hit  = (rd_data_ff.v6 == cur_ff.v6) && (rd_data_ff.plen == cur_ff.plen)
                 && (rd_data_ff.hi == cur_ff.hi) && (rd_data_ff.lo == cur_ff.lo);
      pfx_hit  = (rd_data_ff.v6 == cur_ff.v6)
                 && (((ipal_key(rd_data_ff.v6, rd_data_ff.hi, rd_data_ff.lo)
                      ^ ipal_key(cur_ff.v6, cur_ff.hi, cur_ff.lo)) & pfx_mask) == 128'd0);
      hit_now  = (cur_ff.op == OP_ADD) ? dup_hit : pfx_hit;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      rd_cnt_in    = rd_cnt_ff;
      cmp_vld_in   = cmp_vld_ff;
      cmp_last_in  = cmp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_wdata    = '{v6: cur_ff.v6, hi: cur_ff.hi, lo: cur_ff.lo, plen: cur_ff.plen};

      case (state_ff)
         S_IDLE: begin
            if (q_valid && out_free) begin
               q_pop                   = 1'b1;
               cur_in                  = q_item;
               rsp_data_in.status      = STAT_OK;
               rsp_data_in.hit         = 1'b0;
               rsp_data_in.entry_count = 9'(count_ff);
               rsp_valid_in            = 1'b1;
               case (q_item.op)
                  OP_CLEAR: begin
                     count_in                = '0;
                     rsp_data_in.entry_count = 9'd0;
                  end
                  OP_ADD_BAD: begin
                     rsp_data_in.status = full ? STAT_FULL : STAT_INVALID;
                  end
                  OP_ADD: begin
                     if (full) begin
                        rsp_data_in.status = STAT_FULL;
                     end else if (count_ff == '0) begin
                        mem_we    = 1'b1;
                        mem_wdata = '{v6: q_item.v6, hi: q_item.hi, lo: q_item.lo,
                                      plen: q_item.plen};
                        count_in                = count_inc;
                        rsp_data_in.entry_count = 9'(count_inc);
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_SCAN;
                        rd_cnt_in    = '0;
                        cmp_vld_in   = 1'b0;
                     end
                  end
                  OP_LOOKUP: begin
                     if (count_ff != '0) begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_SCAN;
                        rd_cnt_in    = '0;
                        cmp_vld_in   = 1'b0;
                     end
                  end
                  default: begin
                     rsp_data_in.status = STAT_INVALID;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (rd_cnt_ff < count_ff) begin
               rd_cnt_in   = rd_cnt_ff + CNT_W'(1);
               cmp_vld_in  = 1'b1;
               cmp_last_in = (rd_cnt_in == count_ff);
            end else begin
               cmp_vld_in = 1'b0;
            end
            if (cmp_vld_ff && (hit_now || cmp_last_ff)) begin
               state_in                = S_IDLE;
               cmp_vld_in              = 1'b0;
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = STAT_OK;
               rsp_data_in.hit         = 1'b0;
               rsp_data_in.entry_count = 9'(count_ff);
               if (cur_ff.op == OP_ADD) begin
                  if (hit_now) begin
                     rsp_data_in.status = STAT_PRESENT;
                  end else begin
                     mem_we                  = 1'b1;
                     count_in                = count_inc;
                     rsp_data_in.entry_count = 9'(count_inc);
                  end
               end else begin
                  rsp_data_in.hit = hit_now;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rd_cnt_ff   <= rd_cnt_in;
      cmp_last_ff <= cmp_last_in;
      rsp_data_ff <= rsp_data_in;
   end

   // entry table, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, rsp_data_ff};

   `IPAL_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_W'(MAX_ENTRIES))
   `IPAL_ASSERT(a_scan_out_empty, clock, reset, (state_ff == S_SCAN) |-> !rsp_valid_ff)
   `IPAL_ASSERT(a_scan_nonempty, clock, reset, (state_ff == S_SCAN) |-> (count_ff != '0))
   `IPAL_ASSERT_NEVER(a_write_full, clock, reset, mem_we && full)

endmodule

// File: hw/rtl/ip_prefix_allowlist_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_prefix_allowlist_match
// allowlist of ipv4 and ipv6 host or prefix entries with clear, add, lookup
// ----------------------------------------------------------------------------
// req channel: one command word per transfer, rsp channel: one result word
// per command, in order.
// the front classifies each word and queues it, two words deep; the back
// owns the entry table and answers one word at a time.
// clear, an unused command, a rejected add and any command on an empty table
// answer straight from the idle state. an add or lookup on a table of n
// entries scans the table one entry a cycle and stops early when a match
// is found, so a scan covers at most MAX_ENTRIES entries.
// the back takes a new word every cycle for short commands while rsp_tready
// is high, and finishes a scan before it takes the next word.
// reset empties the table and the queue; entry contents need no clearing.
// while rsp_tready is low the result holds and the queue still accepts
// words until it fills, then req_tready drops.
// ----------------------------------------------------------------------------
module ip_prefix_allowlist_match import ipal_pkg::*; #(
   parameter int MAX_ENTRIES = IPAL_MAX_ENTRIES
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [135:0]  req_tdata,   // addr_hi, addr_lo, prefix_len
   input  logic [2:0]    req_tuser,   // command, is_v6
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [15:0]   rsp_tdata    // status, hit, entry_count, zero pad
);

   logic          push_valid;
   ipal_item_type push_item;
   logic          q_valid;
   ipal_item_type q_item;
   logic          q_pop;

   ipal_front u_front (
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_item  (push_item)
   );

   ipal_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .push_ready (req_tready),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .pop        (q_pop)
   );

   ipal_back #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
